>>> rtl/dhmc_pkg.sv
// ----------------------------------------------------------------------------
// dhmc_pkg
// Shared types and codes for the desk height move controller.
// ----------------------------------------------------------------------------
package dhmc_pkg;

  localparam int unsigned HW = 10;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_TARGET  = 2'd2;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [7:0] SPEED_IDLE = 8'd64;
  localparam logic [7:0] SPEED_DOWN = 8'd65;
  localparam logic [7:0] SPEED_UP   = 8'd66;
  localparam logic [7:0] MIN_PAYLOAD = 8'd4;

  localparam logic [HW-1:0] TOL_Q       = 10'd2;
  localparam logic [HW-1:0] STALL_TOL_Q = 10'd1;

  localparam logic [2:0] CFG_POLLING_MODE = 3'd0;
  localparam logic [2:0] CFG_MIN_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_MAX_HEIGHT   = 3'd2;
  localparam logic [2:0] CFG_STALL_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_IDLE_LIMIT   = 3'd4;

  typedef struct packed {
    logic [1:0]    opcode;
    logic [7:0]    height_byte;
    logic [7:0]    speed_code;
    logic [7:0]    payload_len;
    logic [HW-1:0] target_q;
  } in_t;

  typedef struct packed {
    logic [1:0]    drive_command;
    logic          read_request;
    logic          height_published;
    logic [HW-1:0] height_q;
    logic [1:0]    direction;
    logic          target_rejected;
  } out_t;

  typedef struct packed {
    logic          polling_mode;
    logic [HW-1:0] min_height_q;
    logic [HW-1:0] max_height_q;
    logic [7:0]    stall_limit;
    logic [3:0]    idle_limit;
  } cfg_t;

  typedef struct packed {
    logic          height_known;
    logic [HW-1:0] current_height;
    logic [HW-1:0] target_height;
    logic [HW-1:0] last_move_height;
    logic [7:0]    stall_count;
    logic [3:0]    idle_count;
    logic          under_control;
    logic [1:0]    motion_dir;
    logic [7:0]    last_height_byte;
    logic [7:0]    last_speed_code;
  } st_t;

endpackage

>>> rtl/dhmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dhmc_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module dhmc_cfg_regs import dhmc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [HW-1:0] cfg_wdata,
  output cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polling_mode <= 1'b0;
      cfg.min_height_q <= 10'd260;
      cfg.max_height_q <= 10'd520;
      cfg.stall_limit  <= 8'd10;
      cfg.idle_limit   <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLLING_MODE: cfg.polling_mode <= cfg_wdata[0];
        CFG_MIN_HEIGHT:   cfg.min_height_q <= cfg_wdata;
        CFG_MAX_HEIGHT:   cfg.max_height_q <= cfg_wdata;
        CFG_STALL_LIMIT:  cfg.stall_limit  <= cfg_wdata[7:0];
        CFG_IDLE_LIMIT:   cfg.idle_limit   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/dhmc_engine.sv
// ----------------------------------------------------------------------------
// dhmc_engine
// Controller state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module dhmc_engine import dhmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  st_t  st;
  st_t  st_next;
  logic [1:0] cmd;
  logic       rd;
  logic       pub;
  logic       rej;
  logic       reached;
  logic [7:0] sc_inc;
  logic [3:0] ic_inc;

  function automatic logic [HW-1:0] clamp_q(input logic [HW-1:0] v,
                                            input logic [HW-1:0] lo,
                                            input logic [HW-1:0] hi);
    logic [HW-1:0] t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

  function automatic logic [HW-1:0] abs_diff(input logic [HW-1:0] a,
                                             input logic [HW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  always_comb begin
    case (st.motion_dir)
      DIR_UP:   reached = ({1'b0, st.current_height} + {1'b0, TOL_Q}) >=
                          {1'b0, st.target_height};
      DIR_DOWN: reached = {1'b0, st.current_height} <=
                          ({1'b0, st.target_height} + {1'b0, TOL_Q});
      DIR_IDLE: reached = cfg.polling_mode ? !st.under_control : 1'b1;
      default:  reached = 1'b1;
    endcase
    sc_inc = (st.stall_count != 8'hFF) ? st.stall_count + 8'd1 : st.stall_count;
    ic_inc = (st.idle_count != 4'hF) ? st.idle_count + 4'd1 : st.idle_count;
  end

  always_comb begin
    st_next = st;
    cmd     = CMD_NONE;
    rd      = 1'b0;
    pub     = 1'b0;
    rej     = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        rd = cfg.polling_mode && (st.under_control || st.motion_dir != DIR_IDLE);
        if (st.under_control) begin
          if (reached) begin
            cmd                   = CMD_STOP;
            st_next.motion_dir    = DIR_IDLE;
            st_next.under_control = 1'b0;
          end else if (abs_diff(st.current_height, st.last_move_height) <= STALL_TOL_Q &&
                       sc_inc > cfg.stall_limit) begin
            st_next.stall_count = sc_inc;
            if ({1'b0, st.target_height} + {1'b0, TOL_Q} >= {1'b0, cfg.max_height_q}) begin
              st_next.current_height = cfg.max_height_q;
              st_next.height_known   = 1'b1;
              pub                    = 1'b1;
            end else if ({1'b0, st.target_height} <=
                         {1'b0, cfg.min_height_q} + {1'b0, TOL_Q}) begin
              st_next.current_height = cfg.min_height_q;
              st_next.height_known   = 1'b1;
              pub                    = 1'b1;
            end
            cmd                   = CMD_STOP;
            st_next.motion_dir    = DIR_IDLE;
            st_next.under_control = 1'b0;
          end else begin
            if (abs_diff(st.current_height, st.last_move_height) <= STALL_TOL_Q) begin
              st_next.stall_count = sc_inc;
            end else begin
              st_next.stall_count      = 8'd0;
              st_next.last_move_height = st.current_height;
            end
            if (cfg.polling_mode) begin
              if (st.motion_dir == DIR_IDLE) begin
                st_next.idle_count = ic_inc;
                if (ic_inc > cfg.idle_limit) begin
                  cmd                   = CMD_STOP;
                  st_next.under_control = 1'b0;
                end
              end else begin
                st_next.idle_count = 4'd0;
              end
            end
            if (st.motion_dir == DIR_UP) begin
              cmd = CMD_UP;
            end else if (st.motion_dir == DIR_DOWN) begin
              cmd = CMD_DOWN;
            end
          end
        end
      end
      OP_MEASURE: begin
        if (item.payload_len >= MIN_PAYLOAD &&
            !(item.height_byte == st.last_height_byte &&
              item.speed_code == st.last_speed_code)) begin
          st_next.last_height_byte = item.height_byte;
          st_next.last_speed_code  = item.speed_code;
          if (item.speed_code == SPEED_IDLE) begin
            st_next.motion_dir = DIR_IDLE;
          end else if (item.speed_code == SPEED_UP) begin
            st_next.motion_dir = DIR_UP;
          end else if (item.speed_code == SPEED_DOWN) begin
            st_next.motion_dir = DIR_DOWN;
          end
          st_next.current_height = clamp_q({item.height_byte, 2'b00},
                                           cfg.min_height_q, cfg.max_height_q);
          st_next.height_known   = 1'b1;
          pub                    = 1'b1;
        end
      end
      OP_TARGET: begin
        rd = cfg.polling_mode;
        if (!st.height_known && st.last_height_byte == 8'd0) begin
          rej = 1'b1;
        end else begin
          if (!st.height_known) begin
            st_next.current_height = clamp_q({st.last_height_byte, 2'b00},
                                             cfg.min_height_q, cfg.max_height_q);
            st_next.height_known   = 1'b1;
            pub                    = 1'b1;
          end
          if (st.motion_dir != DIR_IDLE) begin
            cmd                   = CMD_STOP;
            st_next.motion_dir    = DIR_IDLE;
            st_next.under_control = 1'b0;
          end
          st_next.target_height = clamp_q(item.target_q, cfg.min_height_q,
                                          cfg.max_height_q);
          if (abs_diff(st_next.current_height, st_next.target_height) > TOL_Q) begin
            st_next.under_control    = 1'b1;
            st_next.last_move_height = st_next.current_height;
            st_next.stall_count      = 8'd0;
            if (cfg.polling_mode) begin
              st_next.idle_count = 4'd0;
            end
            st_next.motion_dir = (st_next.target_height > st_next.current_height) ?
                                 DIR_UP : DIR_DOWN;
          end
        end
      end
      default: ;
    endcase
  end

  assign result.drive_command    = cmd;
  assign result.read_request     = rd;
  assign result.height_published = pub;
  assign result.height_q         = st_next.current_height;
  assign result.direction        = st_next.motion_dir;
  assign result.target_rejected  = rej;

endmodule

>>> rtl/desk_height_move_controller_top.sv
// ----------------------------------------------------------------------------
// desk_height_move_controller_top
// Up/down position controller for a motorized desk.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_data  (in_t)
//   out      source     out_valid / out_stall  out_data (out_t)
//   cfg      sink       cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle sustained while the result is not stalled; an item passes
// through the input register and then the result register before its result
// can transfer.
// The controller state updates as an item moves from the input register
// into the result register.
// Synchronous reset clears state and pipeline valids and restores the
// configuration defaults.
// A stalled result holds the input register; input stalls only then.
// ----------------------------------------------------------------------------
module desk_height_move_controller_top import dhmc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [HW-1:0] cfg_wdata
);

  cfg_t cfg;
  in_t  item;
  logic item_valid;
  logic adv;
  out_t res;

  assign adv      = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !adv;

  dhmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dhmc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (adv),
    .item   (item),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
      end else if (adv) begin
        item_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
    if (adv) begin
      out_data <= res;
    end
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("transfer into result register lost");

  a_up_cmd_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.drive_command == CMD_UP) |-> out_data.direction == DIR_UP)
    else $error("drive up issued without up direction");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.target_rejected) |->
      (out_data.drive_command == CMD_NONE && !out_data.height_published))
    else $error("rejected target produced a command or height update");

endmodule
